>>> hw/rtl/sia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types and constants for the sorted insert array unit.
// ----------------------------------------------------------------------------
package sia_pkg;

   // Storage geometry
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int KEY_W  = 32;

   // Action codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_LOOKUP = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // Limit after reset
   localparam logic [6:0] LIMIT_RESET = 7'd64;

   // Request transaction
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] key_value;
      logic [5:0]  position;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [31:0] read_value;
      logic [5:0]  placed_at;
      logic [6:0]  entry_count;
      logic [1:0]  status;
   } rsp_type;

endpackage

>>> hw/rtl/sia_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sia_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sorted_insert_array_unit.sv
`timescale 1ns / 1ps
// Sequence: lookup reads the addressed entry and then responds; insert scans down from the
//   top, moving each stored key not less than the new key up one slot, then writes the key;
//   remove pulls each key above the removed index down one slot; rejects and no-ops respond.
// Throughput: one transaction at a time, one key moved per RAM read/write; a new
//   request is taken while the previous response still waits in the output register.
// Reset: synchronous; clears the key count, sets the limit to 64; keys are not cleared.
// ----------------------------------------------------------------------------
// sorted_insert_array_unit
// Sorted key store in one RAM: insert with shift-up, lookup, remove with
// shift-down, one key moved per cycle.
// ----------------------------------------------------------------------------
module sorted_insert_array_unit
   import sia_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [6:0] csr_write_data
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_CHK  = 6'b000010,
      S_WKEY = 6'b000100,
      S_LKP  = 6'b001000,
      S_MOV  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [6:0]         limit_ff;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [KEY_W-1:0]   res_value_ff, res_value_in;
   logic [5:0]         res_placed_ff, res_placed_in;
   logic [CNT_W-1:0]   res_count_ff, res_count_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic [CNT_W-1:0]   eff_limit;
   logic [CNT_W-1:0]   pos_ext;
   logic [CNT_W-1:0]   cnt_m1;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [KEY_W-1:0]   wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [KEY_W-1:0]   rd_data;

   sia_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign pos_ext    = CNT_W'(req_data.position);
   assign cnt_m1     = count_ff - CNT_W'(1);

   // Limit above the storage depth acts as the depth
   always_comb begin
      if (CNT_W'(limit_ff) > CNT_W'(DEPTH)) begin
         eff_limit = CNT_W'(DEPTH);
      end else begin
         eff_limit = CNT_W'(limit_ff);
      end
   end

   // Sequencer: start, scan/shift and completion
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      res_value_in  = res_value_ff;
      res_placed_in = res_placed_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data;
      rd_addr       = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               key_in        = req_data.key_value;
               res_value_in  = '0;
               res_placed_in = '0;
               res_count_in  = count_ff;
               res_status_in = ST_OK;
               state_in      = S_DONE;
               case (req_data.action)
                  ACT_INSERT: begin
                     if (count_ff >= eff_limit) begin
                        res_status_in = ST_FULL;
                     end else begin
                        res_count_in = count_ff + CNT_W'(1);
                        if (count_ff == '0) begin
                           idx_in   = '0;
                           state_in = S_WKEY;
                        end else begin
                           // scan down from the top entry
                           idx_in   = ADDR_W'(cnt_m1);
                           rd_addr  = ADDR_W'(cnt_m1);
                           state_in = S_CHK;
                        end
                     end
                  end
                  ACT_LOOKUP: begin
                     if (pos_ext >= count_ff) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        rd_addr  = ADDR_W'(req_data.position);
                        state_in = S_LKP;
                     end
                  end
                  ACT_REMOVE: begin
                     if (pos_ext >= count_ff) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        res_count_in = cnt_m1;
                        if (pos_ext != cnt_m1) begin
                           idx_in   = ADDR_W'(req_data.position);
                           rd_addr  = ADDR_W'(pos_ext + CNT_W'(1));
                           state_in = S_MOV;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_CHK: begin
            if (!(rd_data < key_ff)) begin
               // entry not less than key: move it up one slot
               wr_en   = 1'b1;
               wr_addr = idx_ff + ADDR_W'(1);
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = S_WKEY;
               end else begin
                  idx_in  = idx_ff - ADDR_W'(1);
                  rd_addr = idx_ff - ADDR_W'(1);
               end
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = S_WKEY;
            end
         end

         S_WKEY: begin
            wr_en         = 1'b1;
            wr_addr       = idx_ff;
            wr_data       = key_ff;
            res_placed_in = 6'(idx_ff);
            state_in      = S_DONE;
         end

         S_LKP: begin
            res_value_in = rd_data;
            state_in     = S_DONE;
         end

         S_MOV: begin
            // pull the next key down into the hole
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            if (CNT_W'(idx_ff) + CNT_W'(2) == count_ff) begin
               state_in = S_DONE;
            end else begin
               idx_in  = idx_ff + ADDR_W'(1);
               rd_addr = idx_ff + ADDR_W'(2);
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.read_value  = res_value_ff;
               rsp_data_in.placed_at   = res_placed_ff;
               rsp_data_in.entry_count = 7'(res_count_ff);
               rsp_data_in.status      = res_status_ff;
               count_in                = res_count_ff;
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      res_value_ff  <= res_value_in;
      res_placed_ff <= res_placed_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/sia_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_checker
// Port-level checks for the sorted insert array unit, bound to the top level.
// ----------------------------------------------------------------------------
module sia_checker
   import sia_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // No response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Count never exceeds the storage depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_count <= 7'(DEPTH)))
      else $error("entry count beyond depth");

   // Rejected transactions carry zero data
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FULL || rsp_data.status == ST_RANGE)
      |-> (rsp_data.read_value == '0) && (rsp_data.placed_at == '0))
      else $error("rejected transaction with nonzero data");

   // Status is always one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_FULL ||
                     rsp_data.status == ST_RANGE))
      else $error("undefined status code");

endmodule

bind sorted_insert_array_unit sia_checker u_sia_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/sorted_store_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_store_checker
// Watches the request, response and CSR ports of the sorted insert array
// unit, keeps a shadow copy of the sorted key store and the capacity limit,
// predicts one response per accepted request and compares every accepted
// response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_store_checker
   import sia_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [6:0] csr_write_data,
   output int         mismatch_count,
   output int         outstanding,
   output logic [6:0] tracked_count
);

   // Shadow state of the store
   logic [KEY_W-1:0] shadow_keys [0:DEPTH-1];
   logic [6:0]       shadow_total;
   logic [6:0]       shadow_limit;

   // Responses predicted but not yet seen, oldest first
   rsp_type          due_responses [$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      tracked_count  = '0;
      shadow_total   = '0;
      shadow_limit   = LIMIT_RESET;
   end

   // Count a failure; only the first few get printed
   task automatic flag_error(input string msg);
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= 10) begin
         $display("%0t ERROR: %s", $time, msg);
      end
   endtask

   // Apply one request to the shadow store and return the response it causes
   task automatic predict_store_op(input req_type op, output rsp_type result);
      int unsigned at;
      int unsigned cap;
      begin
         result = '0;
         result.status = ST_OK;
         cap = (shadow_limit > DEPTH) ? DEPTH : shadow_limit;
         case (op.action)
            ACT_INSERT: begin
               if (shadow_total >= cap) begin
                  result.status = ST_FULL;
               end else begin
                  // new key lands before the first key that is not smaller
                  at = 0;
                  while (at < shadow_total && shadow_keys[at] < op.key_value) at++;
                  for (int i = shadow_total; i > at; i--) shadow_keys[i] = shadow_keys[i-1];
                  shadow_keys[at]  = op.key_value;
                  shadow_total     = shadow_total + 7'd1;
                  result.placed_at = at[5:0];
               end
            end
            ACT_LOOKUP: begin
               if (op.position >= shadow_total) result.status = ST_RANGE;
               else result.read_value = shadow_keys[op.position];
            end
            ACT_REMOVE: begin
               if (op.position >= shadow_total) begin
                  result.status = ST_RANGE;
               end else begin
                  for (int i = op.position; i + 1 < shadow_total; i++) begin
                     shadow_keys[i] = shadow_keys[i+1];
                  end
                  shadow_total = shadow_total - 7'd1;
               end
            end
            default: ;  // unused code leaves the store alone
         endcase
         result.entry_count = shadow_total;
      end
   endtask

   // Monitor all ports at the clock edge
   always @(posedge clock) begin : watch
      rsp_type predicted;
      rsp_type oldest;
      if (reset) begin
         shadow_total = '0;
         shadow_limit = LIMIT_RESET;
         due_responses.delete();
      end else begin
         if (csr_write_enable) shadow_limit = csr_write_data;

         // accepted request transaction
         if (req_valid && !req_stall) begin
            predict_store_op(req_data, predicted);
            due_responses.push_back(predicted);
         end

         // accepted response transaction
         if (rsp_valid && !rsp_stall) begin
            if (due_responses.size() == 0) begin
               flag_error($sformatf(
                  "no transaction pending: value=%h at=%0d count=%0d status=%0d",
                  rsp_data.read_value, rsp_data.placed_at, rsp_data.entry_count,
                  rsp_data.status));
            end else begin
               oldest = due_responses.pop_front();
               if (rsp_data.read_value  !== oldest.read_value  ||
                   rsp_data.placed_at   !== oldest.placed_at   ||
                   rsp_data.entry_count !== oldest.entry_count ||
                   rsp_data.status      !== oldest.status) begin
                  flag_error($sformatf(
                     "exp value=%h at=%0d n=%0d st=%0d, got value=%h at=%0d n=%0d st=%0d",
                     oldest.read_value, oldest.placed_at, oldest.entry_count,
                     oldest.status, rsp_data.read_value, rsp_data.placed_at,
                     rsp_data.entry_count, rsp_data.status));
               end
            end
         end
      end
      outstanding   <= due_responses.size();
      tracked_count <= shadow_total;
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sorted insert array unit: a directed pass over
// empty, full, out-of-range and limit corner cases, then random phases with
// several capacity limits and idle/stall patterns, one long response hold-off.
// ----------------------------------------------------------------------------
module tb_top
   import sia_pkg::*;
();

   localparam int         CLK_PERIOD = 4;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int         HOLD_CYCLES = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 1'b0;
   logic [6:0] csr_write_data = '0;

   int         mismatch_count;
   int         outstanding;
   logic [6:0] tracked_count;

   // Idle pattern controls
   int         tx_idle_pct = 0;
   int         rx_stall_pct = 0;
   logic       hold_toggle = 1'b0;
   logic       hold_seen = 1'b0;
   int         hold_left = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   sorted_insert_array_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   sorted_store_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding),
      .tracked_count    (tracked_count)
   );

   // Response side: long hold-off on request, else random stalls
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
      end
   end

   // Offer one request transaction, idling at random beforehand
   task automatic offer(input req_type item);
      while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send(input logic [1:0] act, input logic [31:0] key, input logic [5:0] pos);
      req_type item;
      item.action    = act;
      item.key_value = key;
      item.position  = pos;
      offer(item);
   endtask

   // Stop sending and wait for every predicted response
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_limit(input logic [6:0] lim);
      csr_write_enable <= 1'b1;
      csr_write_data   <= lim;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random request; keys lean toward duplicates and extremes,
   // positions toward the live part of the store
   function automatic req_type make_item(input int insert_pct);
      req_type item;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) begin
         item.action = ACT_INSERT;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 3) item.action = ACT_UNUSED;
         else if (pick < 50) item.action = ACT_LOOKUP;
         else item.action = ACT_REMOVE;
      end
      pick = $urandom_range(0, 7);
      if (pick < 2) begin
         item.key_value = $urandom_range(0, 15);
      end else if (pick == 2) begin
         case ($urandom_range(0, 3))
            0: item.key_value = 32'h0000_0000;
            1: item.key_value = 32'hFFFF_FFFF;
            2: item.key_value = 32'h8000_0000;
            default: item.key_value = 32'h7FFF_FFFF;
         endcase
      end else begin
         item.key_value = $urandom;
      end
      if (tracked_count != 0 && $urandom_range(0, 9) < 8)
         item.position = 6'($urandom_range(0, tracked_count - 1));
      else
         item.position = 6'($urandom_range(0, 63));
      return item;
   endfunction

   // One random phase: fill toward the limit, then drain toward empty
   task automatic run_phase(input logic [6:0] lim, input int tx_pct, input int rx_pct,
                            input int n_items, input bit long_hold);
      int cap;
      bit filling;
      settle();
      write_limit(lim);
      tx_idle_pct   = tx_pct;
      rx_stall_pct <= rx_pct;
      if (long_hold) hold_toggle <= ~hold_toggle;
      cap     = (lim > DEPTH) ? DEPTH : lim;
      filling = 1'b1;
      for (int i = 0; i < n_items; i++) begin
         if (tracked_count >= cap) filling = 1'b0;
         else if (tracked_count == 0) filling = 1'b1;
         offer(make_item(filling ? 75 : 25));
      end
      settle();
   endtask

   // Stimulus and verdict
   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty store, ordering, equal keys, full table
      write_limit(7'd4);
      send(ACT_LOOKUP, 32'h0, 6'd0);
      send(ACT_REMOVE, 32'h0, 6'd63);
      send(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63);
      send(ACT_INSERT, 32'hFFFF_FFFF, 6'd0);
      send(ACT_INSERT, 32'h0000_0000, 6'd0);
      send(ACT_INSERT, 32'h8000_0000, 6'd0);
      send(ACT_INSERT, 32'h8000_0000, 6'd0);
      send(ACT_INSERT, 32'h0000_0005, 6'd0);
      send(ACT_LOOKUP, 32'h0, 6'd3);
      send(ACT_LOOKUP, 32'h0, 6'd4);
      send(ACT_LOOKUP, 32'h0, 6'd63);
      send(ACT_REMOVE, 32'h0, 6'd3);
      send(ACT_REMOVE, 32'h0, 6'd0);

      // Limit lowered below the current count
      settle();
      write_limit(7'd1);
      send(ACT_INSERT, 32'h1, 6'd0);
      send(ACT_REMOVE, 32'h0, 6'd1);
      send(ACT_INSERT, 32'h2, 6'd0);
      send(ACT_REMOVE, 32'h0, 6'd0);
      send(ACT_INSERT, 32'h7, 6'd0);

      // Zero limit, then a limit above the depth
      settle();
      write_limit(7'd0);
      send(ACT_INSERT, 32'h3, 6'd0);
      send(ACT_LOOKUP, 32'h0, 6'd0);
      settle();
      write_limit(7'd127);
      send(ACT_INSERT, 32'h7, 6'd0);
      send(ACT_REMOVE, 32'h0, 6'd1);

      // Random phases
      run_phase(7'd64, 0, 0, 200, 1'b0);
      run_phase(7'd127, 67, 0, 150, 1'b0);
      run_phase(7'd1, 0, 67, 80, 1'b0);
      run_phase(7'($urandom_range(2, 8)), 27, 27, 150, 1'b0);
      run_phase(7'd64, 0, 0, 120, 1'b1);
      run_phase(7'd0, 27, 27, 40, 1'b0);
      run_phase(7'($urandom_range(1, 64)), 0, 67, 160, 1'b0);

      settle();
      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
